// ===== sv/u8dec_pkg.sv =====
`timescale 1ns / 1ps

package u8dec_pkg;

    localparam int CP_W = 21;
    localparam logic [CP_W-1:0] REPLACEMENT_CHAR = 21'h00FFFD;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_EMIT
    } ctrl_state_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic emit;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;
        logic pend_last;
        logic new_has_results;
    } dp_status_t;

endpackage

// ===== sv/u8dec_ctrl.sv =====
`timescale 1ns / 1ps

module u8dec_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  u8dec_pkg::dp_status_t status,
    output u8dec_pkg::dp_cmd_t    cmd
);

    u8dec_pkg::ctrl_state_t state_reg;
    u8dec_pkg::ctrl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= u8dec_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // outputs
    always_comb begin
        s_tready   = 1'b0;
        cmd.accept = 1'b0;
        cmd.emit   = 1'b0;
        case (state_reg)
            u8dec_pkg::ST_IDLE: begin
                s_tready = 1'b1;
            end
            u8dec_pkg::ST_EMIT: begin
                cmd.emit = status.out_free;
                s_tready = status.out_free && status.pend_last;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
        cmd.accept = s_tvalid && s_tready;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            u8dec_pkg::ST_IDLE: begin
                if (s_tvalid && status.new_has_results) begin
                    state_next = u8dec_pkg::ST_EMIT;
                end
            end
            u8dec_pkg::ST_EMIT: begin
                if (status.out_free && status.pend_last) begin
                    if (s_tvalid && status.new_has_results) begin
                        state_next = u8dec_pkg::ST_EMIT;
                    end else begin
                        state_next = u8dec_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = u8dec_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/u8dec_datapath.sv =====
`timescale 1ns / 1ps

module u8dec_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [7:0]                    data_byte,
    input  logic                          end_of_string,
    input  u8dec_pkg::dp_cmd_t            cmd,
    output u8dec_pkg::dp_status_t         status,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [u8dec_pkg::CP_W-1:0]    out_code_point,
    output logic                          out_replaced,
    output logic                          out_last
);

    // decoder state
    logic [7:0] held0_reg, held0_next;
    logic [7:0] held1_reg, held1_next;
    logic [7:0] held2_reg, held2_next;
    logic [1:0] held_cnt_reg, held_cnt_next;
    logic [2:0] seq_len_reg, seq_len_next;

    // results waiting for the output register
    logic [2:0]                 rep_cnt_reg, rep_cnt_next;
    logic                       data_pend_reg, data_pend_next;
    logic [u8dec_pkg::CP_W-1:0] data_cp_reg, data_cp_next;

    // output register
    logic                       out_valid_reg, out_valid_next;
    logic [u8dec_pkg::CP_W-1:0] out_cp_reg, out_cp_next;
    logic                       out_repl_reg, out_repl_next;
    logic                       out_last_reg, out_last_next;

    logic [2:0]                 new_rep;
    logic                       new_data;
    logic [u8dec_pkg::CP_W-1:0] new_cp;
    logic [u8dec_pkg::CP_W-1:0] assembled_cp;
    logic                       is_cont;
    logic                       pend_any;
    logic                       pend_last;

    assign is_cont   = (data_byte[7:6] == 2'b10);
    assign pend_any  = (rep_cnt_reg != 3'd0) || data_pend_reg;
    assign pend_last = ((rep_cnt_reg == 3'd1) && !data_pend_reg)
                    || ((rep_cnt_reg == 3'd0) && data_pend_reg);

    always_comb begin
        case (seq_len_reg)
            3'd2: begin
                assembled_cp = {10'd0, held0_reg[4:0], data_byte[5:0]};
            end
            3'd3: begin
                assembled_cp = {5'd0, held0_reg[3:0], held1_reg[5:0], data_byte[5:0]};
            end
            default: begin
                assembled_cp = {held0_reg[2:0], held1_reg[5:0], held2_reg[5:0],
                                data_byte[5:0]};
            end
        endcase
    end

    // decode one byte into a replacement count and an optional code point
    always_comb begin
        held0_next    = held0_reg;
        held1_next    = held1_reg;
        held2_next    = held2_reg;
        held_cnt_next = held_cnt_reg;
        seq_len_next  = seq_len_reg;
        new_rep       = 3'd0;
        new_data      = 1'b0;
        new_cp        = {13'd0, data_byte};
        if ((seq_len_reg != 3'd0) && is_cont) begin
            if (({1'b0, held_cnt_reg} + 3'd1) >= seq_len_reg) begin
                new_data      = 1'b1;
                new_cp        = assembled_cp;
                seq_len_next  = 3'd0;
                held_cnt_next = 2'd0;
            end else begin
                case (held_cnt_reg)
                    2'd1: begin
                        held1_next = data_byte;
                    end
                    2'd2: begin
                        held2_next = data_byte;
                    end
                    default: begin
                        held2_next = held2_reg;
                    end
                endcase
                held_cnt_next = held_cnt_reg + 2'd1;
                if (end_of_string) begin
                    new_rep       = {1'b0, held_cnt_next};
                    seq_len_next  = 3'd0;
                    held_cnt_next = 2'd0;
                end
            end
        end else begin
            // cut off any open sequence, then take the byte afresh
            new_rep       = (seq_len_reg != 3'd0) ? {1'b0, held_cnt_reg} : 3'd0;
            seq_len_next  = 3'd0;
            held_cnt_next = 2'd0;
            case (data_byte) inside
                8'h00: begin
                    new_data = 1'b0;
                end
                [8'h01:8'h7F]: begin
                    new_data = 1'b1;
                end
                [8'hC0:8'hDF]: begin
                    held0_next    = data_byte;
                    held_cnt_next = 2'd1;
                    seq_len_next  = 3'd2;
                end
                [8'hE0:8'hEF]: begin
                    held0_next    = data_byte;
                    held_cnt_next = 2'd1;
                    seq_len_next  = 3'd3;
                end
                [8'hF0:8'hF7]: begin
                    held0_next    = data_byte;
                    held_cnt_next = 2'd1;
                    seq_len_next  = 3'd4;
                end
                default: begin
                    new_rep = new_rep + 3'd1;
                end
            endcase
            if (end_of_string && (seq_len_next != 3'd0)) begin
                new_rep       = new_rep + 3'd1;
                seq_len_next  = 3'd0;
                held_cnt_next = 2'd0;
            end
        end
    end

    assign status.out_free        = !out_valid_reg || out_ready;
    assign status.pend_last       = pend_last;
    assign status.new_has_results = (new_rep != 3'd0) || new_data;

    // pending results and output register
    always_comb begin
        rep_cnt_next   = rep_cnt_reg;
        data_pend_next = data_pend_reg;
        data_cp_next   = data_cp_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_cp_next    = out_cp_reg;
        out_repl_next  = out_repl_reg;
        out_last_next  = out_last_reg;
        if (cmd.emit) begin
            out_valid_next = 1'b1;
            out_last_next  = pend_last;
            if (rep_cnt_reg != 3'd0) begin
                out_cp_next   = u8dec_pkg::REPLACEMENT_CHAR;
                out_repl_next = 1'b1;
                rep_cnt_next  = rep_cnt_reg - 3'd1;
            end else begin
                out_cp_next    = data_cp_reg;
                out_repl_next  = 1'b0;
                data_pend_next = 1'b0;
            end
        end
        if (cmd.accept) begin
            rep_cnt_next   = new_rep;
            data_pend_next = new_data;
            data_cp_next   = new_cp;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_cnt_reg  <= 2'd0;
            seq_len_reg   <= 3'd0;
            rep_cnt_reg   <= 3'd0;
            data_pend_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.accept) begin
                held_cnt_reg <= held_cnt_next;
                seq_len_reg  <= seq_len_next;
            end
            rep_cnt_reg   <= rep_cnt_next;
            data_pend_reg <= data_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            held0_reg <= held0_next;
            held1_reg <= held1_next;
            held2_reg <= held2_next;
        end
        data_cp_reg  <= data_cp_next;
        out_cp_reg   <= out_cp_next;
        out_repl_reg <= out_repl_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid      = out_valid_reg;
    assign out_code_point = out_cp_reg;
    assign out_replaced   = out_repl_reg;
    assign out_last       = out_last_reg;

    a_rep_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        rep_cnt_reg <= 3'd4)
        else $error("too many pending replacements");

    a_emit_has_work: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> pend_any)
        else $error("emit with nothing pending");

    a_accept_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.accept |-> (!pend_any || (cmd.emit && pend_last)))
        else $error("byte taken while results still pending");

    a_data_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_repl_reg) |-> out_last_reg)
        else $error("decoded code point not last of its run");

    a_open_seq_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (seq_len_reg != 3'd0) |-> ((held_cnt_reg != 2'd0)
                                   && ({1'b0, held_cnt_reg} < seq_len_reg)))
        else $error("held byte count out of range for open sequence");

endmodule

// ===== sv/utf8_code_point_decoder_unit.sv =====
`timescale 1ns / 1ps
// results wait in the pending-result counter and go one at a time into the output register
// throughput: a byte giving at most one result is taken every cycle unless the output stalls
// a byte giving n results (up to four, from a cut-off sequence) holds the input until the
// last is emitted; one result leaves the output register per cycle while m_tready is high
// reset: synchronous, clears the open sequence, pending results and the output valid

module utf8_code_point_decoder_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte
    input  logic        s_tlast,   // end_of_string
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // code_point, zero pad
    output logic        m_tuser,   // replaced
    output logic        m_tlast    // last_of_run
);

    u8dec_pkg::dp_cmd_t         cmd;
    u8dec_pkg::dp_status_t      status;
    logic [u8dec_pkg::CP_W-1:0] code_point;

    u8dec_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    u8dec_datapath u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .data_byte      (s_tdata),
        .end_of_string  (s_tlast),
        .cmd            (cmd),
        .status         (status),
        .out_ready      (m_tready),
        .out_valid      (m_tvalid),
        .out_code_point (code_point),
        .out_replaced   (m_tuser),
        .out_last       (m_tlast)
    );

    assign m_tdata = {3'b000, code_point};

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;

    typedef logic [u8dec_pkg::CP_W-1:0] cp_t;

    typedef struct packed {
        cp_t  code_point;
        logic replaced;
        logic last_of_run;
    } cp_result_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    // decoder shadow state
    logic [7:0] lead_buf [3];
    logic [1:0] buf_cnt  = 2'd0;
    logic [2:0] seq_len  = 3'd0;

    cp_result_t cp_expected [$];
    int         errors     = 0;
    int         stall_left = 0;
    bit         calm       = 1'b0;

    utf8_code_point_decoder_unit i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #1 aclk = ~aclk;

    initial begin
        #1_000_000;
        $display("tb: done, errors");
        $finish;
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(6, 20);
    endfunction

    function automatic void push_cp(input cp_t cp, input logic repl);
        cp_result_t r;
        r.code_point  = cp;
        r.replaced    = repl;
        r.last_of_run = 1'b0;
        cp_expected = {cp_expected, r};
    endfunction

    function automatic void clear_seq();
        lead_buf[0] = 8'h00;
        lead_buf[1] = 8'h00;
        lead_buf[2] = 8'h00;
        buf_cnt     = 2'd0;
        seq_len     = 3'd0;
    endfunction

    // replacement for the lead, then one per held continuation byte
    function automatic void abort_seq();
        int k;
        if (seq_len == 3'd0) return;
        push_cp(u8dec_pkg::REPLACEMENT_CHAR, 1'b1);
        for (k = 1; k < int'(buf_cnt); k++) push_cp(u8dec_pkg::REPLACEMENT_CHAR, 1'b1);
        clear_seq();
    endfunction

    function automatic void start_byte(input logic [7:0] b);
        if (b == 8'h00) begin
            return;
        end else if (b[7] == 1'b0) begin
            push_cp(cp_t'(b), 1'b0);
        end else if (b[7:5] == 3'b110) begin
            lead_buf[0] = b; buf_cnt = 2'd1; seq_len = 3'd2;
        end else if (b[7:4] == 4'b1110) begin
            lead_buf[0] = b; buf_cnt = 2'd1; seq_len = 3'd3;
        end else if (b[7:3] == 5'b11110) begin
            lead_buf[0] = b; buf_cnt = 2'd1; seq_len = 3'd4;
        end else begin
            push_cp(u8dec_pkg::REPLACEMENT_CHAR, 1'b1);
        end
    endfunction

    function automatic void finish_seq(input logic [7:0] b);
        cp_t cp;
        case (seq_len)
            3'd2:    cp = cp_t'({lead_buf[0][4:0], b[5:0]});
            3'd3:    cp = cp_t'({lead_buf[0][3:0], lead_buf[1][5:0], b[5:0]});
            default: cp = {lead_buf[0][2:0], lead_buf[1][5:0], lead_buf[2][5:0], b[5:0]};
        endcase
        push_cp(cp, 1'b0);
        clear_seq();
    endfunction

    function automatic void decode_byte(input logic [7:0] b, input logic eos);
        int         first;
        cp_result_t r;
        first = cp_expected.size();
        if (seq_len != 3'd0 && b[7:6] == 2'b10) begin
            if (int'(buf_cnt) + 1 >= int'(seq_len)) begin
                finish_seq(b);
            end else if (buf_cnt < 2'd3) begin
                lead_buf[buf_cnt] = b;
                buf_cnt = buf_cnt + 2'd1;
            end else begin
                clear_seq();
            end
        end else begin
            abort_seq();
            start_byte(b);
        end
        if (eos || b == 8'h00) abort_seq();
        if (cp_expected.size() > first) begin
            r = cp_expected[cp_expected.size() - 1];
            r.last_of_run = 1'b1;
            cp_expected[cp_expected.size() - 1] = r;
        end
    endfunction

    always @(posedge aclk) begin
        if (stall_left > 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_tready   <= 1'b1;
            stall_left <= pick_gap();
        end
    end

    always @(negedge aclk) begin
        cp_result_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (cp_expected.size() == 0) begin
                $error("unexpected transaction: code_point %h", m_tdata);
                errors++;
            end else begin
                e = cp_expected.pop_front();
                if (m_tdata !== 24'(e.code_point)) begin
                    $error("code_point: expected %h, actual %h", e.code_point, m_tdata);
                    errors++;
                end
                if (m_tuser !== e.replaced) begin
                    $error("replaced: expected %b, actual %b", e.replaced, m_tuser);
                    errors++;
                end
                if (m_tlast !== e.last_of_run) begin
                    $error("last_of_run: expected %b, actual %b", e.last_of_run, m_tlast);
                    errors++;
                end
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic eos);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eos;
        do @(negedge aclk); while (!s_tready);
        @(posedge aclk);
        decode_byte(b, eos);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (cp_expected.size() != 0);
    endtask

    task automatic test_ascii();
        send_byte(8'h7F, 1'b0);
        send_byte(8'h01, 1'b1);
        send_byte(8'h00, 1'b0);
    endtask

    task automatic test_multibyte();
        logic [7:0] seq_bytes [9];
        int k;
        seq_bytes = '{8'hC2, 8'h80, 8'hE0, 8'hA0, 8'h80, 8'hF7, 8'hBF, 8'hBF, 8'hBF};
        for (k = 0; k < 9; k++) send_byte(seq_bytes[k], 1'b0);
    endtask

    task automatic test_malformed();
        // bad leads
        send_byte(8'h80, 1'b0);
        send_byte(8'hFF, 1'b0);
        // bad continuation after one held byte
        send_byte(8'hE2, 1'b0);
        send_byte(8'h82, 1'b0);
        send_byte(8'h41, 1'b0);
        // four results from one byte
        send_byte(8'hF0, 1'b0);
        send_byte(8'h90, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h5A, 1'b0);
        // cut off by end of string
        send_byte(8'hC3, 1'b1);
        // cut off by a zero byte
        send_byte(8'hF4, 1'b0);
        send_byte(8'h8F, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'h00, 1'b0);
    endtask

    task automatic test_random_strings(input int n_bytes);
        logic [7:0] str_q [$];
        logic [7:0] nb;
        int         sent;
        int         kind;
        int         len;
        int         cut;
        int         k;
        logic       eos;
        sent = 0;
        while (sent < n_bytes) begin
            str_q.delete();
            repeat ($urandom_range(1, 6)) begin
                kind = $urandom_range(0, 99);
                len  = $urandom_range(1, 4);
                if (kind < 8) begin
                    nb = 8'($urandom);
                    str_q = {str_q, nb};
                end else begin
                    case (len)
                        1:       nb = 8'($urandom_range(1, 127));
                        2:       nb = {3'b110, 5'($urandom)};
                        3:       nb = {4'b1110, 4'($urandom)};
                        default: nb = {5'b11110, 3'($urandom)};
                    endcase
                    str_q = {str_q, nb};
                    cut = (kind < 18 && len > 1) ? $urandom_range(1, len - 1) : 0;
                    for (k = 1; k < len - cut; k++) begin
                        nb = {2'b10, 6'($urandom)};
                        str_q = {str_q, nb};
                    end
                end
            end
            kind = $urandom_range(0, 3);
            eos  = (kind == 1 || kind == 2);
            if (kind == 0) begin
                nb = 8'h00;
                str_q = {str_q, nb};
                eos = 1'($urandom);
            end
            for (k = 0; k < str_q.size(); k++)
                send_byte(str_q[k], eos && k == str_q.size() - 1);
            sent += str_q.size();
        end
    endtask

    initial begin
        clear_seq();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_ascii();
        test_multibyte();
        test_malformed();
        drain();
        test_random_strings(95);
        drain();
        calm = 1'b1;
        test_random_strings(40);
        calm = 1'b0;
        test_random_strings(90);
        drain();
        repeat (20) @(posedge aclk);
        if (errors == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
